### design/tpid_pkg.sv
// Shared widths, register codes, reset values and types of the thermocouple PID controller.
package tpid_pkg;

  localparam int RAW_W      = 16;
  localparam int TEMP_W     = 12;
  localparam int GAIN_W     = 24;
  localparam int ILIM_W     = 15;
  localparam int HYST_W     = 12;
  localparam int CNT_W      = 8;
  localparam int DUTY_W     = 8;
  localparam int INTEG_W    = 16;
  localparam int ERR_W      = TEMP_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int DUTY_DIV          = 1024;
  localparam int PID_SHIFT         = $clog2(DUTY_DIV);

  localparam int PROD_W = INTEG_W + GAIN_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ILIM      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RESIDENCY = 3'd6;

  localparam logic [RAW_W-1:0] SENSOR_MASK = 16'h8002;
  localparam int               OPEN_BIT    = 2;
  localparam int               TEMP_LSB    = 3;

  localparam logic [GAIN_W-1:0] KP_RESET   = 24'sd4096;
  localparam logic [GAIN_W-1:0] KI_RESET   = 24'sd256;
  localparam logic [GAIN_W-1:0] KD_RESET   = -24'sd14336;
  localparam logic [ILIM_W-1:0] ILIM_RESET = 15'd768;
  localparam logic [HYST_W-1:0] HYST_RESET = 12'd20;
  localparam logic [CNT_W-1:0]  NEED_RESET = 8'd60;

  localparam logic [DUTY_W-1:0] DUTY_MAX      = 8'd255;
  localparam logic [DUTY_W-1:0] HEATER_ON_MIN = 8'd8;

  typedef struct packed {
    logic [TEMP_W-1:0] target;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [ILIM_W-1:0] ilim;
    logic [HYST_W-1:0] hyst;
    logic [CNT_W-1:0]  need;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic              present;
    logic              open_tc;
    logic              at_temp;
  } flags_t;

  typedef struct packed {
    logic [ERR_W-1:0]   err;
    logic [INTEG_W-1:0] integ;
    logic [ERR_W-1:0]   deriv;
    flags_t             flags;
  } s1_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              heater_on;
    flags_t            flags;
  } res_t;

endpackage

### design/tpid_in_if.sv
// Input channel carrying one raw converter word per transfer.
interface tpid_in_if;
  logic                        valid;
  logic                        ready;
  logic [tpid_pkg::RAW_W-1:0]  raw_reading;

  modport source (output valid, output raw_reading, input ready);
  modport sink   (input valid, input raw_reading, output ready);
endinterface

### design/tpid_out_if.sv
// Result channel carrying heater drive and status per transfer.
interface tpid_out_if;
  logic                         valid;
  logic                         ready;
  logic [tpid_pkg::DUTY_W-1:0]  heater_duty;
  logic                         heater_on;
  logic [tpid_pkg::TEMP_W-1:0]  temperature;
  logic                         sensor_present;
  logic                         thermocouple_open;
  logic                         at_temperature;

  modport source (output valid, output heater_duty, output heater_on, output temperature,
                  output sensor_present, output thermocouple_open, output at_temperature,
                  input ready);
  modport sink   (input valid, input heater_duty, input heater_on, input temperature,
                  input sensor_present, input thermocouple_open, input at_temperature,
                  output ready);
endinterface

### design/tpid_hist.sv
// Temperature history ring with a prefetched oldest entry for the derivative term.
module tpid_hist #(
  parameter int HISTORY_DEPTH = tpid_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [tpid_pkg::TEMP_W-1:0] wr_data,
  output logic [tpid_pkg::TEMP_W-1:0] oldest
);
  import tpid_pkg::*;

  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(HISTORY_DEPTH - 1);

  logic [TEMP_W-1:0]        mem [HISTORY_DEPTH];
  logic [PW-1:0]            pos_r;
  logic [HISTORY_DEPTH-1:0] vld_r;
  logic [TEMP_W-1:0]        rd_r;
  logic                     rd_vld_r;
  logic                     byp_r;
  logic [TEMP_W-1:0]        byp_data_r;
  logic [PW-1:0]            pos1;
  logic [PW-1:0]            pos2;

  assign pos1 = (pos_r == LAST) ? '0 : pos_r + 1'b1;
  assign pos2 = (pos1 == LAST) ? '0 : pos1 + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else if (step) begin
      pos_r        <= pos1;
      vld_r[pos_r] <= 1'b1;
      rd_vld_r     <= vld_r[pos2];
      byp_r        <= (pos2 == pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      mem[pos_r] <= wr_data;
      rd_r       <= mem[pos2];
      byp_data_r <= wr_data;
    end
  end

  assign oldest = byp_r ? byp_data_r : (rd_vld_r ? rd_r : '0);

endmodule

### design/tpid_front.sv
// Sensor decode, residency tracking, integrator and error terms into the first register.
module tpid_front #(
  parameter int HISTORY_DEPTH = tpid_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tpid_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tpid_pkg::RAW_W-1:0] raw,
  output logic                       s1_valid,
  input  logic                       s1_ready,
  output tpid_pkg::s1_t              s1
);
  import tpid_pkg::*;

  logic               step;
  logic               present;
  logic               open_tc;
  logic [TEMP_W-1:0]  held_r;
  logic [TEMP_W-1:0]  held_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [INTEG_W-1:0] integ_r;
  logic [INTEG_W-1:0] integ_nxt;
  logic [TEMP_W-1:0]  oldest;
  logic [ERR_W-1:0]   err;
  logic [ERR_W-1:0]   err_abs;
  logic [TEMP_W-1:0]  temp_gap;
  logic [ERR_W-1:0]   deriv;
  logic signed [INTEG_W:0] acc;
  logic signed [INTEG_W:0] lim_pos;
  logic signed [INTEG_W:0] lim_neg;
  logic               s1_valid_r;
  s1_t                s1_r;

  assign in_ready = !s1_valid_r || s1_ready;
  assign step     = in_valid && in_ready && (cfg.target != '0);

  assign present  = (raw & SENSOR_MASK) == '0;
  assign open_tc  = present && raw[OPEN_BIT];
  assign held_nxt = (present && !open_tc) ? raw[TEMP_LSB +: TEMP_W] : held_r;

  assign err      = {1'b0, cfg.target} - {1'b0, held_nxt};
  assign err_abs  = err[ERR_W-1] ? -err : err;
  assign temp_gap = err_abs[TEMP_W-1:0];

  always_comb begin
    if (temp_gap > cfg.hyst) begin
      cnt_nxt = '0;
    end else if (cnt_r < cfg.need) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  assign lim_pos = $signed({2'b00, cfg.ilim});
  assign lim_neg = -lim_pos;
  assign acc = $signed({integ_r[INTEG_W-1], integ_r})
             + $signed({{(INTEG_W + 1 - ERR_W){err[ERR_W-1]}}, err});

  always_comb begin
    if (acc > lim_pos) begin
      integ_nxt = lim_pos[INTEG_W-1:0];
    end else if (acc < lim_neg) begin
      integ_nxt = lim_neg[INTEG_W-1:0];
    end else begin
      integ_nxt = acc[INTEG_W-1:0];
    end
  end

  tpid_hist #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .wr_data (held_nxt),
    .oldest  (oldest)
  );

  assign deriv = {1'b0, held_nxt} - {1'b0, oldest};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      cnt_r      <= '0;
      integ_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (step) begin
        held_r  <= held_nxt;
        cnt_r   <= cnt_nxt;
        integ_r <= integ_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_r.err           <= err;
      s1_r.integ         <= integ_nxt;
      s1_r.deriv         <= deriv;
      s1_r.flags.temp    <= held_nxt;
      s1_r.flags.present <= present;
      s1_r.flags.open_tc <= open_tc;
      s1_r.flags.at_temp <= cnt_nxt >= cfg.need;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

### design/tpid_back.sv
// Gain multiplies, scaled sum, duty clamp and the result register.
module tpid_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tpid_pkg::cfg_t cfg,
  input  logic           s1_valid,
  output logic           s1_ready,
  input  tpid_pkg::s1_t  s1,
  output logic           out_valid,
  input  logic           out_ready,
  output tpid_pkg::res_t res
);
  import tpid_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_ADJ = SUM_W'(DUTY_DIV - 1);
  localparam logic signed [SUM_W-1:0] Q_MAX     = SUM_W'(DUTY_MAX);

  logic                     s2_valid_r;
  logic                     s2_ready;
  logic signed [PROD_W-1:0] pp_r;
  logic signed [PROD_W-1:0] pi_r;
  logic signed [PROD_W-1:0] pd_r;
  flags_t                   s2_flags_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  adj;
  logic signed [SUM_W-1:0]  q;
  logic [DUTY_W-1:0]        duty;
  logic                     out_valid_r;
  res_t                     res_r;

  assign s2_ready = !out_valid_r || out_ready;
  assign s1_ready = !s2_valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      pp_r       <= PROD_W'($signed(s1.err)) * PROD_W'($signed(cfg.kp));
      pi_r       <= PROD_W'($signed(s1.integ)) * PROD_W'($signed(cfg.ki));
      pd_r       <= PROD_W'($signed(s1.deriv)) * PROD_W'($signed(cfg.kd));
      s2_flags_r <= s1.flags;
    end
  end

  assign sum = SUM_W'(pp_r) + SUM_W'(pi_r) + SUM_W'(pd_r);
  assign adj = sum[SUM_W-1] ? sum + ROUND_ADJ : sum;
  assign q   = adj >>> PID_SHIFT;

  always_comb begin
    if (q[SUM_W-1]) begin
      duty = '0;
    end else if (q > Q_MAX) begin
      duty = DUTY_MAX;
    end else begin
      duty = q[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s2_valid_r <= s1_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && s2_ready) begin
      res_r.duty      <= duty;
      res_r.heater_on <= duty >= HEATER_ON_MIN;
      res_r.flags     <= s2_flags_r;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

### design/thermocouple_pid_heater_controller.sv
// Thermocouple PID heater controller top level: register file, control path and channels.
// Each transfer on in_ch is one control tick with a raw converter word; while the target
// register is zero the tick is taken and dropped with no result and no state change.
// Otherwise one result reaches out_ch through a decode/integrator register, a gain multiply
// register and the result register. A new tick is taken every cycle while out_ch keeps up;
// the integrator, residency counter and history ring all update in the cycle of the
// transfer, so nothing waits on an earlier tick.
// Configuration writes are taken every cycle and should be made while no tick is in flight.
module thermocouple_pid_heater_controller #(
  parameter int HISTORY_DEPTH = tpid_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tpid_in_if.sink                         in_ch,
  tpid_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tpid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpid_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tpid_pkg::*;

  cfg_t cfg_r;
  logic s1_valid;
  logic s1_ready;
  s1_t  s1;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= '0;
      cfg_r.kp     <= KP_RESET;
      cfg_r.ki     <= KI_RESET;
      cfg_r.kd     <= KD_RESET;
      cfg_r.ilim   <= ILIM_RESET;
      cfg_r.hyst   <= HYST_RESET;
      cfg_r.need   <= NEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET:    cfg_r.target <= cfg_data[TEMP_W-1:0];
        REG_KP:        cfg_r.kp     <= cfg_data[GAIN_W-1:0];
        REG_KI:        cfg_r.ki     <= cfg_data[GAIN_W-1:0];
        REG_KD:        cfg_r.kd     <= cfg_data[GAIN_W-1:0];
        REG_ILIM:      cfg_r.ilim   <= cfg_data[ILIM_W-1:0];
        REG_HYST:      cfg_r.hyst   <= cfg_data[HYST_W-1:0];
        REG_RESIDENCY: cfg_r.need   <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tpid_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .raw      (in_ch.raw_reading),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  tpid_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1        (s1),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.heater_duty       = res.duty;
  assign out_ch.heater_on         = res.heater_on;
  assign out_ch.temperature       = res.flags.temp;
  assign out_ch.sensor_present    = res.flags.present;
  assign out_ch.thermocouple_open = res.flags.open_tc;
  assign out_ch.at_temperature    = res.flags.at_temp;

endmodule

### design/tpid_checker.sv
// Port-level assertions for the thermocouple PID heater controller and their bind.
module tpid_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tpid_pkg::DUTY_W-1:0] heater_duty,
  input logic                        heater_on,
  input logic [tpid_pkg::TEMP_W-1:0] temperature,
  input logic                        sensor_present,
  input logic                        thermocouple_open
);
  import tpid_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(heater_duty) && $stable(temperature))
    else $error("result changed while stalled");

  a_on_matches_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> heater_on == (heater_duty >= HEATER_ON_MIN))
    else $error("heater_on disagrees with duty");

  a_open_needs_sensor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && thermocouple_open |-> sensor_present)
    else $error("open thermocouple reported without sensor");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind thermocouple_pid_heater_controller tpid_checker u_tpid_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .heater_duty       (out_ch.heater_duty),
  .heater_on         (out_ch.heater_on),
  .temperature       (out_ch.temperature),
  .sensor_present    (out_ch.sensor_present),
  .thermocouple_open (out_ch.thermocouple_open)
);

### sim/tpid_result_checker.sv
// Result checker for the thermocouple PID controller: tracks settings, predicts each tick, compares.
module tpid_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  tpid_in_if                              in_ch,
  tpid_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [tpid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpid_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import tpid_pkg::*;

  localparam int                RING_W    = $clog2(HISTORY_DEPTH_DEF);
  localparam logic [RING_W-1:0] RING_LAST = RING_W'(HISTORY_DEPTH_DEF - 1);

  logic [TEMP_W-1:0]        set_target;
  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [GAIN_W-1:0] kd;
  logic [ILIM_W-1:0]        ilim;
  logic [HYST_W-1:0]        hyst;
  logic [CNT_W-1:0]         need;

  logic [TEMP_W-1:0] held_temp;
  logic [TEMP_W-1:0] recent_temps [HISTORY_DEPTH_DEF];
  logic [RING_W-1:0] ring_idx;
  logic [CNT_W-1:0]  settled;
  int                integ;

  res_t heater_results_due[$];

  task automatic report_mismatch(string msg);
    $display("tpid mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic compare_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic reset_controller_state();
    set_target   = '0;
    kp           = KP_RESET;
    ki           = KI_RESET;
    kd           = KD_RESET;
    ilim         = ILIM_RESET;
    hyst         = HYST_RESET;
    need         = NEED_RESET;
    held_temp    = '0;
    recent_temps = '{default: '0};
    ring_idx     = '0;
    settled      = '0;
    integ        = 0;
  endtask

  task automatic apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TARGET:    set_target = data[TEMP_W-1:0];
      REG_KP:        kp = data[GAIN_W-1:0];
      REG_KI:        ki = data[GAIN_W-1:0];
      REG_KD:        kd = data[GAIN_W-1:0];
      REG_ILIM:      ilim = data[ILIM_W-1:0];
      REG_HYST:      hyst = data[HYST_W-1:0];
      REG_RESIDENCY: need = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic res_t control_tick(logic [RAW_W-1:0] raw);
    int     t;
    int     tgt;
    int     err;
    int     gap;
    int     lim;
    int     acc;
    int     deriv;
    longint total;
    longint q;
    res_t   r;
    r = '0;
    if ((raw & SENSOR_MASK) == '0) begin
      r.flags.present = 1'b1;
      if (raw[OPEN_BIT]) r.flags.open_tc = 1'b1;
      else held_temp = raw[TEMP_LSB +: TEMP_W];
    end
    recent_temps[ring_idx] = held_temp;
    ring_idx = (ring_idx == RING_LAST) ? '0 : ring_idx + 1'b1;

    t   = int'(held_temp);
    tgt = int'(set_target);
    gap = (t >= tgt) ? t - tgt : tgt - t;
    if (gap > int'(hyst)) settled = '0;
    else if (settled < need) settled = settled + 1'b1;

    err = tgt - t;
    lim = int'(ilim);
    acc = integ + err;
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    integ = acc;

    deriv = t - int'(recent_temps[ring_idx]);
    total = longint'(err) * longint'(kp) + longint'(integ) * longint'(ki)
          + longint'(deriv) * longint'(kd);
    q = total / DUTY_DIV;
    if (q > longint'(DUTY_MAX)) r.duty = DUTY_MAX;
    else if (q < 0) r.duty = '0;
    else r.duty = q[DUTY_W-1:0];

    r.heater_on     = (r.duty >= HEATER_ON_MIN);
    r.flags.temp    = held_temp;
    r.flags.at_temp = (settled >= need);
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      reset_controller_state();
      heater_results_due.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (heater_results_due.size() == 0) begin
          report_mismatch($sformatf("result transfer with none due, duty %0d temp %0d",
                                    out_ch.heater_duty, out_ch.temperature));
        end else begin
          want = heater_results_due.pop_front();
          compare_field("heater_duty", int'(out_ch.heater_duty), int'(want.duty));
          compare_field("heater_on", int'(out_ch.heater_on), int'(want.heater_on));
          compare_field("temperature", int'(out_ch.temperature), int'(want.flags.temp));
          compare_field("sensor_present", int'(out_ch.sensor_present),
                        int'(want.flags.present));
          compare_field("thermocouple_open", int'(out_ch.thermocouple_open),
                        int'(want.flags.open_tc));
          compare_field("at_temperature", int'(out_ch.at_temperature),
                        int'(want.flags.at_temp));
        end
      end
      if (in_ch.valid && in_ch.ready && set_target != '0)
        heater_results_due.push_back(control_tick(in_ch.raw_reading));
      if (cfg_we) apply_setting(cfg_index, cfg_data);
    end
    pending <= heater_results_due.size();
  end

endmodule

### sim/tb_thermocouple_pid_heater_controller.sv
// Testbench top for the thermocouple PID controller: clock, reset, ticks, settings and verdict.
module tb_thermocouple_pid_heater_controller;
  import tpid_pkg::*;

  localparam int RUN_LIMIT   = 300000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_GAP  = 6;
  localparam int TEMP_MAX    = (1 << TEMP_W) - 1;
  localparam int ID_LOW_BIT  = 1;
  localparam int DIR_TARGET  = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_seq       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  tpid_in_if  in_ch ();
  tpid_out_if out_ch ();

  thermocouple_pid_heater_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tpid_result_checker heater_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      IDLE_SENDER:   begin send_idle_pct = 78; recv_stall_pct <= 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct <= 78; end
      default:       begin send_idle_pct = 25; recv_stall_pct <= 25; end
    endcase
  endtask

  task automatic send_tick(logic [RAW_W-1:0] raw);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.raw_reading <= raw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(logic [CFG_DATA_W-1:0] target, logic [CFG_DATA_W-1:0] p,
                               logic [CFG_DATA_W-1:0] i, logic [CFG_DATA_W-1:0] d,
                               logic [CFG_DATA_W-1:0] lim, logic [CFG_DATA_W-1:0] band,
                               logic [CFG_DATA_W-1:0] settle);
    write_reg(REG_TARGET, target);
    write_reg(REG_KP, p);
    write_reg(REG_KI, i);
    write_reg(REG_KD, d);
    write_reg(REG_ILIM, lim);
    write_reg(REG_HYST, band);
    write_reg(REG_RESIDENCY, settle);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    if ($urandom_range(1)) return CFG_DATA_W'($urandom());
    return CFG_DATA_W'($urandom_range(40000) - 20000);
  endfunction

  task automatic run_phase(int target, int count, bit with_hold);
    int               level;
    int               pick;
    logic [RAW_W-1:0] word;
    level = $urandom_range(TEMP_MAX);
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 4) hold_seq <= hold_seq + 1;
      if (n == count / 2) drain_results();
      level = level + (target - level) / 8 + int'($urandom_range(8)) - 4;
      if ($urandom_range(49) == 0) level = $urandom_range(TEMP_MAX);
      if (level < 0) level = 0;
      if (level > TEMP_MAX) level = TEMP_MAX;
      pick    = $urandom_range(99);
      word    = RAW_W'(level) << TEMP_LSB;
      word[0] = 1'($urandom_range(1));
      if (pick >= 80 && pick < 87) begin
        word[OPEN_BIT] = 1'b1;
      end else if (pick >= 87 && pick < 93) begin
        word = word | SENSOR_MASK;
        if ($urandom_range(1)) word[RAW_W-1] = 1'b0;
        else word[ID_LOW_BIT] = 1'b0;
      end else if (pick >= 93) begin
        word = RAW_W'($urandom());
      end
      send_tick(word);
    end
  endtask

  initial begin
    int target;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.raw_reading <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_TARGET;
    cfg_data          <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(IDLE_NONE);
    send_tick(16'h1234);
    send_tick(16'hFFFF);
    drain_results();
    write_reg(REG_UNUSED, 24'hFFFFFF);
    write_reg(REG_TARGET, 24'hABC000 | CFG_DATA_W'(DIR_TARGET));
    write_reg(REG_RESIDENCY, 24'h123403);
    send_tick(16'h0000);
    send_tick(16'h7FF8);
    send_tick(16'hFFFF);
    send_tick(16'h8000 | RAW_W'(DIR_TARGET << TEMP_LSB));
    send_tick(16'h0002 | RAW_W'(DIR_TARGET << TEMP_LSB));
    send_tick(16'h0004 | RAW_W'(DIR_TARGET << TEMP_LSB));
    send_tick(RAW_W'(DIR_TARGET << TEMP_LSB));
    send_tick(16'h0001 | RAW_W'(DIR_TARGET << TEMP_LSB));
    send_tick(RAW_W'(DIR_TARGET << TEMP_LSB));
    send_tick(RAW_W'(DIR_TARGET << TEMP_LSB));
    send_tick(RAW_W'((DIR_TARGET + 20) << TEMP_LSB));
    send_tick(RAW_W'((DIR_TARGET + 21) << TEMP_LSB));
    send_tick(RAW_W'((DIR_TARGET - 20) << TEMP_LSB));
    send_tick(RAW_W'((DIR_TARGET - 21) << TEMP_LSB));
    drain_results();
    write_reg(REG_RESIDENCY, '0);
    send_tick(16'h0000);
    send_tick(16'h0004);
    send_tick(16'h7FFD);

    for (int p = 0; p < 7; p++) begin
      drain_results();
      if (p == 4) begin
        write_reg(REG_TARGET, '0);
        for (int k = 0; k < 15; k++) send_tick(RAW_W'($urandom()));
        drain_results();
      end
      case (p)
        0: begin
          target = 1000;
          load_settings(CFG_DATA_W'(target), KP_RESET, KI_RESET, KD_RESET,
                        CFG_DATA_W'(ILIM_RESET), CFG_DATA_W'(HYST_RESET), 24'd5);
        end
        1: begin
          target = TEMP_MAX;
          load_settings(CFG_DATA_W'(target), 24'h7FFFFF, 24'h800000, '0, 24'h007FFF, '0,
                        24'd200);
        end
        2: begin
          target = 1;
          load_settings(CFG_DATA_W'(target), 24'h800000, 24'h7FFFFF, 24'h7FFFFF, '0,
                        24'h000FFF, 24'd255);
        end
        3: begin
          target = $urandom_range(TEMP_MAX, 1);
          load_settings(CFG_DATA_W'(target), pick_gain(), pick_gain(), pick_gain(),
                        CFG_DATA_W'($urandom_range(32767)), CFG_DATA_W'($urandom_range(64)),
                        '0);
        end
        4: begin
          target = 800;
          load_settings(CFG_DATA_W'(target), KP_RESET, KI_RESET, KD_RESET,
                        CFG_DATA_W'(ILIM_RESET), CFG_DATA_W'(HYST_RESET),
                        CFG_DATA_W'(NEED_RESET));
        end
        default: begin
          target = $urandom_range(TEMP_MAX, 1);
          load_settings(CFG_DATA_W'(target), pick_gain(), pick_gain(), pick_gain(),
                        CFG_DATA_W'($urandom_range(32767)), CFG_DATA_W'($urandom_range(100)),
                        CFG_DATA_W'($urandom_range(40)));
        end
      endcase
      set_idling(idle_mode_e'(p % 4));
      run_phase(target, (p == 2) ? 300 : 240, p == 0 || p == 3);
    end

    drain_results();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
